// ===== hdl/sapc_pkg.sv =====
// ============================================================================
// sapc_pkg - shared types and constants for the sensor calibration block
// Field widths, fixed-point formats and codes used by the datapath modules.
// ============================================================================
package sapc_pkg;

    // Field widths of the stream items
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int POW_W    = 3;
    localparam int COEFF_W  = 32;
    localparam int DISP_W   = 48;
    localparam int ORDER_W  = 3;

    // Packed stream widths (zero filled to whole bytes)
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Polynomial limits
    localparam int NUM_COEFF = 6;
    localparam int MAX_ORDER = 5;

    // Voltage in unsigned Q3.16, never above 5.0
    localparam int V_W = 19;

    // Shared multiplier: 17-bit signed chunk of acc times {0, v}
    localparam int CHUNK_W = 16;
    localparam int MUL_A_W = CHUNK_W + 1;
    localparam int MUL_B_W = V_W + 1;
    localparam int PP_W    = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = DISP_W + V_W;
    localparam int SUM_T_W = PROD_W - 16 + 1;

    // Item kinds
    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_COEFF  = 1'b1
    } action_t;

    typedef logic signed [COEFF_W-1:0] coeff_t;
    typedef logic signed [DISP_W-1:0]  disp_t;
    typedef logic [V_W-1:0]            volt_t;

endpackage

// ===== hdl/sapc_div.sv =====
// ============================================================================
// sapc_div - iterative restoring divider
// Produces one quotient bit per cycle. The quotient must fit QUO_W bits,
// so the upper part of the numerator starts as the partial remainder.
// ============================================================================
module sapc_div
    import sapc_pkg::*;
#(
    parameter int DEN_W = 19,
    parameter int QUO_W = 19
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic                   done,
    output logic [QUO_W-1:0]       quo
);

    localparam int NUM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             ge;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            quo_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/sensor_average_poly_calibrate.sv =====
// ============================================================================
// sensor_average_poly_calibrate - moving average and polynomial calibration
// Keeps a short code window per channel, scales the average to a voltage
// and evaluates a per-channel polynomial with Horner's rule.
//
// Channel  | Dir | Fields
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | tuser: action; tdata: channel, raw_sample, coeff_power,
//          |     |        coeff_value
// m_axis   | out | tuser: saturated; tdata: out_channel, displacement
// cfg      | in  | cfg_wdata: poly_order, written when cfg_we is high
//
// A coefficient beat leaves the block idle. A sample beat reads and adds
// each held code (window memory read, then add), runs the bit-serial
// divider (19 steps), then per Horner step makes three passes of the
// 17x20 multiplier and one round/add/clip. s_axis_tready is high only
// while idle; a finished result waits in the output register, so a stalled
// m_axis holds only the next result. Reset clears windows, coefficient
// valid bits and poly_order (to 1); no clearing pass is needed.
// ============================================================================
module sensor_average_poly_calibrate
    import sapc_pkg::*;
#(
    parameter int WINDOW_LEN = 5,
    parameter int CHANNELS   = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config
    input  logic                   cfg_we,
    input  logic [ORDER_W-1:0]     cfg_wdata,   // poly_order
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // channel, raw_sample, coeff_power, coeff_value
    input  logic                   s_axis_tuser,   // action
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_channel, displacement
    output logic                   m_axis_tuser    // saturated
);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int WDEPTH   = CHANNELS * WINDOW_LEN;
    localparam int WADDR_W  = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CDEPTH   = CHANNELS * NUM_COEFF;
    localparam int CADDR_W  = $clog2(CDEPTH);
    localparam int SUM_W    = SAMPLE_W + FILL_W;
    localparam int DEN_W    = SAMPLE_W + FILL_W;
    localparam int NUM_W    = DEN_W + V_W;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_SUM_RD  = 10'b0000000010,
        S_SUM_ACC = 10'b0000000100,
        S_PREP    = 10'b0000001000,
        S_DIV     = 10'b0000010000,
        S_CRD     = 10'b0000100000,
        S_CLOAD   = 10'b0001000000,
        S_MUL     = 10'b0010000000,
        S_ADD     = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    // Input field unpack
    logic [CHAN_W-1:0]   in_channel;
    logic [SAMPLE_W-1:0] in_sample;
    logic [POW_W-1:0]    in_power;
    coeff_t              in_coeff;
    action_t             in_action;

    assign in_channel = s_axis_tdata[3:0];
    assign in_sample  = s_axis_tdata[19:4];
    assign in_power   = s_axis_tdata[22:20];
    assign in_coeff   = s_axis_tdata[54:23];
    assign in_action  = action_t'(s_axis_tuser);

    // Registers
    state_t                 state_reg, state_next;
    logic [ORDER_W-1:0]     poly_order_reg;
    logic [SLOT_W-1:0]      head_reg [CHANNELS];
    logic [FILL_W-1:0]      fill_reg [CHANNELS];
    logic                   cvalid_reg [CDEPTH];
    logic [CHAN_W-1:0]      ch_reg;
    logic [FILL_W-1:0]      fill_cur_reg;
    logic [FILL_W-1:0]      idx_reg;
    logic [SUM_W-1:0]       sum_reg;
    volt_t                  v_reg;
    logic [ORDER_W-1:0]     order_reg;
    logic [ORDER_W-1:0]     k_reg;
    logic [1:0]             part_reg;
    disp_t                  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   sat_reg;
    logic                   out_valid_reg;
    logic [CHAN_W-1:0]      out_ch_reg;
    disp_t                  out_disp_reg;
    logic                   out_sat_reg;

    // Memories
    logic [SAMPLE_W-1:0]    win_mem [WDEPTH];
    logic [SAMPLE_W-1:0]    win_rdata_reg;
    coeff_t                 coeff_mem [CDEPTH];
    coeff_t                 coeff_rdata_reg;
    logic                   coeff_rvalid_reg;

    // Accept decode
    logic                   in_beat;
    logic                   ch_ok;
    logic [CH_W-1:0]        in_ch_idx;
    logic [CH_W-1:0]        ch_idx;
    logic                   push;
    logic                   cwrite;
    logic [WADDR_W-1:0]     win_waddr;
    logic [WADDR_W-1:0]     win_raddr;
    logic [CADDR_W-1:0]     coeff_waddr;
    logic [CADDR_W-1:0]     coeff_raddr;
    logic [ORDER_W-1:0]     rd_pow;
    logic [SLOT_W-1:0]      head_cur;
    logic [FILL_W-1:0]      fill_cur;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign ch_ok     = (int'(in_channel) < CHANNELS);
    assign in_ch_idx = in_channel[CH_W-1:0];
    assign ch_idx    = ch_reg[CH_W-1:0];
    assign push      = in_beat && ch_ok && (in_action == ACT_SAMPLE);
    assign cwrite    = in_beat && ch_ok && (in_action == ACT_COEFF)
                       && (int'(in_power) < NUM_COEFF);
    assign head_cur  = head_reg[in_ch_idx];
    assign fill_cur  = fill_reg[in_ch_idx];

    assign win_waddr   = WADDR_W'(int'(in_ch_idx) * WINDOW_LEN + int'(head_cur));
    assign win_raddr   = WADDR_W'(int'(ch_idx) * WINDOW_LEN + int'(idx_reg[SLOT_W-1:0]));
    assign coeff_waddr = CADDR_W'(int'(in_ch_idx) * NUM_COEFF + int'(in_power));
    assign rd_pow      = (state_reg == S_CRD) ? order_reg : (k_reg - 1'b1);
    assign coeff_raddr = CADDR_W'(int'(ch_idx) * NUM_COEFF + int'(rd_pow));

    // Window memory
    always_ff @(posedge clk)
    begin
        if (push)
            win_mem[win_waddr] <= in_sample;
        win_rdata_reg <= win_mem[win_raddr];
    end

    // Coefficient memory
    always_ff @(posedge clk)
    begin
        if (cwrite)
            coeff_mem[coeff_waddr] <= in_coeff;
        coeff_rdata_reg <= coeff_mem[coeff_raddr];
    end

    // Coefficient valid bits: unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CDEPTH; i++)
                cvalid_reg[i] <= 1'b0;
            coeff_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cwrite)
                cvalid_reg[coeff_waddr] <= 1'b1;
            coeff_rvalid_reg <= cvalid_reg[coeff_raddr];
        end
    end

    coeff_t coeff_eff;
    assign coeff_eff = coeff_rvalid_reg ? coeff_rdata_reg : '0;

    // Window head and fill per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            head_reg[in_ch_idx] <= (int'(head_cur) + 1 >= WINDOW_LEN) ? '0
                                   : head_cur + SLOT_W'(1);
            if (int'(fill_cur) < WINDOW_LEN)
                fill_reg[in_ch_idx] <= fill_cur + FILL_W'(1);
        end
    end

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_order_reg <= ORDER_W'(1);
        else if (cfg_we)
            poly_order_reg <= cfg_wdata;
    end

    // Voltage: v = round(sum*5*65536 / (65535*fill))
    logic [SUM_W+2:0]  sum5;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  num;
    logic              div_start;
    logic              div_done;
    volt_t             div_quo;

    always_comb
    begin
        sum5 = {sum_reg, 2'b00} + (SUM_W+3)'(sum_reg);
        den  = {fill_cur_reg, 16'b0} - DEN_W'(fill_cur_reg);
        num  = {sum5, 16'b0} + NUM_W'(den >> 1);
    end

    assign div_start = (state_reg == S_PREP);

    sapc_div #(
        .DEN_W (DEN_W),
        .QUO_W (V_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Shared multiplier: one 16-bit chunk of acc per pass
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PP_W-1:0]    pp;
    logic signed [PROD_W-1:0]  pp_ext;
    logic signed [PROD_W-1:0]  pp_shift;

    always_comb
    begin
        case (part_reg)
            2'd0:    mul_a = {1'b0, acc_reg[15:0]};
            2'd1:    mul_a = {1'b0, acc_reg[31:16]};
            default: mul_a = {acc_reg[47], acc_reg[47:32]};
        endcase
        mul_b  = {1'b0, v_reg};
        pp     = mul_a * mul_b;
        pp_ext = {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
        case (part_reg)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = pp_ext <<< 16;
            default: pp_shift = pp_ext <<< 32;
        endcase
    end

    // Horner step: round half up, add coefficient, clip to 48 bits
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [SUM_T_W-1:0] step_sum;
    logic                      clip;
    disp_t                     step_acc;

    always_comb
    begin
        prod_rnd = prod_reg + PROD_W'(32768);
        step_sum = {prod_rnd[PROD_W-1], prod_rnd[PROD_W-1:16]}
                   + {{(SUM_T_W-COEFF_W){coeff_eff[COEFF_W-1]}}, coeff_eff};
        clip     = (step_sum[SUM_T_W-1:DISP_W-1] != '0)
                   && (step_sum[SUM_T_W-1:DISP_W-1] != '1);
        if (!clip)
            step_acc = step_sum[DISP_W-1:0];
        else if (step_sum[SUM_T_W-1])
            step_acc = {1'b1, {(DISP_W-1){1'b0}}};
        else
            step_acc = {1'b0, {(DISP_W-1){1'b1}}};
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (push) state_next = S_SUM_RD;
            S_SUM_RD:  state_next = S_SUM_ACC;
            S_SUM_ACC: state_next = (idx_reg + FILL_W'(1) == fill_cur_reg) ? S_PREP
                                    : S_SUM_RD;
            S_PREP:    state_next = S_DIV;
            S_DIV:     if (div_done) state_next = S_CRD;
            S_CRD:     state_next = S_CLOAD;
            S_CLOAD:   state_next = (order_reg == '0) ? S_DONE : S_MUL;
            S_MUL:     if (part_reg == 2'd2) state_next = S_ADD;
            S_ADD:     state_next = (k_reg == ORDER_W'(1)) ? S_DONE : S_MUL;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ch_reg       <= in_channel;
                fill_cur_reg <= (int'(fill_cur) < WINDOW_LEN) ? fill_cur + FILL_W'(1)
                                : fill_cur;
                idx_reg      <= '0;
                sum_reg      <= '0;
                order_reg    <= (int'(poly_order_reg) > MAX_ORDER) ? ORDER_W'(MAX_ORDER)
                                : poly_order_reg;
            end
            S_SUM_ACC:
            begin
                sum_reg <= sum_reg + SUM_W'(win_rdata_reg);
                idx_reg <= idx_reg + FILL_W'(1);
            end
            S_DIV:
            begin
                if (div_done)
                    v_reg <= div_quo;
            end
            S_CLOAD:
            begin
                acc_reg  <= {{(DISP_W-COEFF_W){coeff_eff[COEFF_W-1]}}, coeff_eff};
                k_reg    <= order_reg;
                sat_reg  <= 1'b0;
                part_reg <= 2'd0;
                prod_reg <= '0;
            end
            S_MUL:
            begin
                prod_reg <= prod_reg + pp_shift;
                part_reg <= part_reg + 2'd1;
            end
            S_ADD:
            begin
                acc_reg  <= step_acc;
                sat_reg  <= sat_reg | clip;
                k_reg    <= k_reg - 1'b1;
                part_reg <= 2'd0;
                prod_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_ch_reg   <= ch_reg;
            out_disp_reg <= acc_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W-DISP_W-CHAN_W)'(0), out_disp_reg, out_ch_reg};
    assign m_axis_tuser  = out_sat_reg;

endmodule
